[src/ppm_sum_frame_decoder_macros.svh]
// Assertion macros for the PPM sum frame decoder.
`ifndef PPM_SUM_FRAME_DECODER_MACROS_SVH
`define PPM_SUM_FRAME_DECODER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled in reset.
`define PSFD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled in reset.
`define PSFD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PSFD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define PSFD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[src/psfd_pkg.sv]
// Types and constants shared by the PPM sum frame decoder modules.
package psfd_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned SLOT_W    = 16;
    localparam int unsigned SEL_W     = 4;
    localparam int unsigned GOOD_W    = 4;
    localparam int unsigned BAD_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_GAP_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_GAP_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_BELOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_ABOVE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MAX    = 3'd5;

    localparam logic [CFG_W-1:0] RST_SYNC_GAP_MIN = 16'd4000;
    localparam logic [CFG_W-1:0] RST_SYNC_GAP_MAX = 16'd21000;
    localparam logic [CFG_W-1:0] RST_BAD_BELOW    = 16'd650;
    localparam logic [CFG_W-1:0] RST_BAD_ABOVE    = 16'd2000;
    localparam logic [CFG_W-1:0] RST_VALID_MIN    = 16'd900;
    localparam logic [CFG_W-1:0] RST_VALID_MAX    = 16'd2100;

    localparam logic [SLOT_W-1:0] RST_SLOT_VALUE = 16'd1500;
    localparam logic [BAD_W-1:0]  BAD_COUNT_MAX  = 8'd255;

    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] sync_gap_min;
        logic [CFG_W-1:0] sync_gap_max;
        logic [CFG_W-1:0] bad_below;
        logic [CFG_W-1:0] bad_above;
        logic [CFG_W-1:0] valid_min;
        logic [CFG_W-1:0] valid_max;
    } cfg_t;

    typedef struct packed {
        logic              wr_en;
        logic              commit;
        logic [SLOT_W-1:0] wr_data;
    } slot_cmd_t;

    typedef struct packed {
        logic [GOOD_W-1:0] valid_count;
        logic              in_sync;
        logic              frame_committed;
    } frame_status_t;

endpackage

[src/psfd_slot_bank.sv]
// Pending and committed slot banks with commit copy and committed read.
module psfd_slot_bank
    import psfd_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  slot_cmd_t                     cmd,
    input  logic [$clog2(SLOT_COUNT)-1:0] wr_index,
    input  logic                          rd_en,
    input  logic [SEL_W-1:0]              rd_slot,
    output logic [SLOT_W-1:0]             rd_value
);

    localparam int unsigned IDX_W = $clog2(SLOT_COUNT);

    logic [SLOT_W-1:0] pending_reg   [SLOT_COUNT];
    logic [SLOT_W-1:0] committed_reg [SLOT_COUNT];
    logic              rd_in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                pending_reg[k]   <= RST_SLOT_VALUE;
                committed_reg[k] <= RST_SLOT_VALUE;
            end
        end else begin
            // copy takes the bank as it was before this request's write
            if (cmd.commit) begin
                for (int k = 0; k < SLOT_COUNT; k++) begin
                    committed_reg[k] <= pending_reg[k];
                end
            end
            if (cmd.wr_en) begin
                pending_reg[wr_index] <= cmd.wr_data;
            end
        end
    end

    assign rd_in_range = ({1'b0, rd_slot} < (SEL_W + 1)'(SLOT_COUNT));

    always_comb begin
        rd_value = '0;
        if (rd_en && rd_in_range) begin
            rd_value = committed_reg[rd_slot[IDX_W-1:0]];
        end
    end

endmodule

[src/psfd_frame_ctrl.sv]
// Interval, sync detection, slot pointer and pulse/error counters.
`include "ppm_sum_frame_decoder_macros.svh"
module psfd_frame_ctrl
    import psfd_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cfg_t                          cfg,
    input  logic                          advance,
    input  logic                          mode,
    input  logic [TIME_W-1:0]             edge_time_us,
    output frame_status_t                 status,
    output slot_cmd_t                     slot_cmd,
    output logic [$clog2(SLOT_COUNT)-1:0] slot_index
);

    localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

    logic [TIME_W-1:0] prev_time_reg, prev_time_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic              sync_reg, sync_next;
    logic [GOOD_W-1:0] good_reg, good_next;
    logic [BAD_W-1:0]  bad_reg, bad_next;

    logic              is_edge;
    logic [TIME_W-1:0] gap;
    logic              sync_gap;
    logic              bad_gap;
    logic              in_range;
    logic              commit;
    logic [IDX_W-1:0]  ptr_a;
    logic [GOOD_W-1:0] good_a;
    logic              sync_a;

    assign is_edge  = advance && (mode == MODE_EDGE);
    assign gap      = edge_time_us - prev_time_reg;
    assign sync_gap = (gap > TIME_W'(cfg.sync_gap_min)) && (gap < TIME_W'(cfg.sync_gap_max));
    assign bad_gap  = (gap > TIME_W'(cfg.bad_above)) || (gap < TIME_W'(cfg.bad_below));
    assign in_range = (gap <= TIME_W'(cfg.valid_max)) && (gap >= TIME_W'(cfg.valid_min));
    assign commit   = sync_gap && (bad_reg == '0);

    assign ptr_a  = sync_gap ? '0 : ptr_reg;
    assign good_a = sync_gap ? '0 : good_reg;
    assign sync_a = sync_gap | sync_reg;

    always_comb begin
        prev_time_next = prev_time_reg;
        ptr_next       = ptr_reg;
        sync_next      = sync_reg;
        good_next      = good_reg;
        bad_next       = bad_reg;
        if (is_edge) begin
            prev_time_next = edge_time_us;
            ptr_next       = ptr_a;
            sync_next      = sync_a;
            good_next      = good_a;
            if (sync_gap) begin
                bad_next = '0;
            end else if (bad_gap && (bad_reg != BAD_COUNT_MAX)) begin
                bad_next = bad_reg + BAD_W'(1);
            end
            if (sync_a) begin
                if (ptr_a == LAST_SLOT) begin
                    sync_next = 1'b0;
                    good_next = '0;
                end else begin
                    ptr_next  = ptr_a + IDX_W'(1);
                    good_next = good_a + GOOD_W'(in_range);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_time_reg <= '0;
            ptr_reg       <= '0;
            sync_reg      <= 1'b0;
            good_reg      <= '0;
            bad_reg       <= '0;
        end else begin
            prev_time_reg <= prev_time_next;
            ptr_reg       <= ptr_next;
            sync_reg      <= sync_next;
            good_reg      <= good_next;
            bad_reg       <= bad_next;
        end
    end

    assign slot_index       = ptr_a;
    assign slot_cmd.wr_en   = is_edge && sync_a;
    assign slot_cmd.commit  = is_edge && commit;
    assign slot_cmd.wr_data = gap[SLOT_W-1:0];

    assign status.valid_count     = good_next;
    assign status.in_sync         = sync_next;
    assign status.frame_committed = is_edge && commit;

    `PSFD_ASSERT_NXT(a_sync_starts_frame, aclk, aresetn, is_edge && sync_gap, sync_reg && (ptr_reg == IDX_W'(1)) && (bad_reg == '0), "sync gap did not restart the frame at slot one")
    `PSFD_ASSERT_NXT(a_read_keeps_state, aclk, aresetn, advance && (mode == MODE_READ), $stable(ptr_reg) && $stable(bad_reg) && $stable(prev_time_reg) && $stable(sync_reg), "read request changed frame state")
    `PSFD_ASSERT_IMP(a_good_le_ptr, aclk, aresetn, 1'b1, {{(GOOD_W){1'b0}}, ptr_reg} >= {{(IDX_W){1'b0}}, good_reg}, "valid count ahead of slot pointer")
    `PSFD_ASSERT_IMP(a_idle_no_count, aclk, aresetn, !sync_reg, good_reg == '0, "valid count held outside sync")

endmodule

[src/ppm_sum_frame_decoder.sv]
// Top level of the PPM sum frame decoder: config registers, input and result stages.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  s_mode, s_edge_time_us, s_read_slot
//  m_       out        m_valid / m_ready  m_valid_count, m_in_sync, m_frame_committed,
//                                         m_slot_value
//  cfg_     in         cfg_wr_en          cfg_wr_index, cfg_wr_data
//
// One request per cycle sustained while m_ready is high; m_valid rises once an accepted
// request is decoded combinationally from the input register into the result register.
// Synchronous active-low reset clears all but the data registers; slot banks reset to 1500 us.
// A stall on m_ready holds the result; s_ready drops only when both stages are full.
module ppm_sum_frame_decoder
    import psfd_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [TIME_W-1:0]    s_edge_time_us,
    input  logic [SEL_W-1:0]     s_read_slot,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [GOOD_W-1:0]    m_valid_count,
    output logic                 m_in_sync,
    output logic                 m_frame_committed,
    output logic [SLOT_W-1:0]    m_slot_value
);

    localparam int unsigned IDX_W = $clog2(SLOT_COUNT);

    cfg_t cfg_reg;

    logic              in_valid_reg, in_valid_next;
    logic              in_mode_reg;
    logic [TIME_W-1:0] in_time_reg;
    logic [SEL_W-1:0]  in_slot_reg;

    logic              out_valid_reg, out_valid_next;
    frame_status_t     out_status_reg;
    logic [SLOT_W-1:0] out_value_reg;

    logic              advance;
    logic              s_accept;
    frame_status_t     status;
    slot_cmd_t         slot_cmd;
    logic [IDX_W-1:0]  slot_index;
    logic [SLOT_W-1:0] rd_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_gap_min <= RST_SYNC_GAP_MIN;
            cfg_reg.sync_gap_max <= RST_SYNC_GAP_MAX;
            cfg_reg.bad_below    <= RST_BAD_BELOW;
            cfg_reg.bad_above    <= RST_BAD_ABOVE;
            cfg_reg.valid_min    <= RST_VALID_MIN;
            cfg_reg.valid_max    <= RST_VALID_MAX;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_SYNC_GAP_MIN: cfg_reg.sync_gap_min <= cfg_wr_data;
                CFG_SYNC_GAP_MAX: cfg_reg.sync_gap_max <= cfg_wr_data;
                CFG_BAD_BELOW:    cfg_reg.bad_below    <= cfg_wr_data;
                CFG_BAD_ABOVE:    cfg_reg.bad_above    <= cfg_wr_data;
                CFG_VALID_MIN:    cfg_reg.valid_min    <= cfg_wr_data;
                CFG_VALID_MAX:    cfg_reg.valid_max    <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_mode_reg <= s_mode;
            in_time_reg <= s_edge_time_us;
            in_slot_reg <= s_read_slot;
        end
        if (advance) begin
            out_status_reg <= status;
            out_value_reg  <= rd_value;
        end
    end

    psfd_frame_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_frame_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .advance      (advance),
        .mode         (in_mode_reg),
        .edge_time_us (in_time_reg),
        .status       (status),
        .slot_cmd     (slot_cmd),
        .slot_index   (slot_index)
    );

    psfd_slot_bank #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_bank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (slot_cmd),
        .wr_index (slot_index),
        .rd_en    (in_mode_reg == MODE_READ),
        .rd_slot  (in_slot_reg),
        .rd_value (rd_value)
    );

    assign m_valid           = out_valid_reg;
    assign m_valid_count     = out_status_reg.valid_count;
    assign m_in_sync         = out_status_reg.in_sync;
    assign m_frame_committed = out_status_reg.frame_committed;
    assign m_slot_value      = out_value_reg;

endmodule
